/* rtl/lcdtf_pkg.sv */
// Shared types and constants of the two-line LCD text frame buffer.
// Used by every module of the block but lcdtf_ram; depends on nothing else.

package lcdtf_pkg;

  // Display geometry and glyph store layout.
  localparam int FRAME_BYTES      = 512;
  localparam int PAGE_COLS        = 128;
  localparam int PAGE_ITEMS       = 131;
  localparam int CMD_ITEMS        = 3;
  localparam int GLYPH_STRIDE     = 25;
  localparam int FONT_GLYPHS      = 96;
  localparam int STORE_BYTES      = 2400;
  localparam int DEF_GLYPH_COLUMNS = 12;

  // The frame buffer is split by address bit 7 into two banks, so a column's
  // upper and lower bytes always land in different banks.
  localparam int FB_BANK_DEPTH   = FRAME_BYTES / 2;
  localparam int FB_AW           = $clog2(FB_BANK_DEPTH);
  // The glyph store is split by address parity into two banks.
  localparam int FONT_BANK_DEPTH = (STORE_BYTES + 1) / 2;
  localparam int FONT_AW         = $clog2(FONT_BANK_DEPTH);

  // Widths of draw addresses and pens.
  localparam int DRAW_AW = 11;
  localparam int PEN_W   = 10;

  localparam logic [DRAW_AW-1:0] LINE1_BASE  = 11'd256;
  localparam logic [PEN_W-1:0]   PEN_MAX     = 10'd1023;
  localparam logic [7:0]         SYM_FIRST   = 8'd32;

  // Display command bytes of the refresh sequence.
  localparam logic [7:0] DISP_COL_LOW  = 8'h00;
  localparam logic [7:0] DISP_COL_HIGH = 8'h10;
  localparam logic [7:0] DISP_PAGE     = 8'hB0;

  // Input op codes.
  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_DRAW  = 3'd1;
  localparam logic [2:0] OP_OR    = 3'd2;
  localparam logic [2:0] OP_FLUSH = 3'd3;
  localparam logic [2:0] OP_LOAD  = 3'd4;

  // Depth of the command queue between front and back.
  localparam int CMD_QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  op;
    logic        line;
    logic [7:0]  symbol;
    logic [6:0]  column;
    logic [1:0]  page;
    logic [7:0]  byte_value;
    logic [11:0] font_address;
    logic [7:0]  font_byte;
  } lcdtf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       frame_last;
    logic       symbol_error;
  } lcdtf_out_t;

  // Classified command kinds handed from front to back.
  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_DRAW,
    CMD_ORB,
    CMD_FLUSH,
    CMD_LOAD,
    CMD_NOP
  } lcdtf_kind_e;

  typedef struct packed {
    lcdtf_kind_e kind;
    logic        line;
    logic        sym_err;
    logic [11:0] glyph;
    logic [8:0]  fb_addr;
    logic [7:0]  data;
    logic [11:0] font_addr;
  } lcdtf_cmd_t;

endpackage

/* rtl/lcdtf_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing else.

module lcdtf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/lcdtf_front.sv */
// Front end: accepts input transfers, classifies them into commands and
// queues them for the back end. Depends on lcdtf_pkg.

module lcdtf_front
  import lcdtf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lcdtf_in_t  in_data_i,
  input  logic       init_busy_i,
  output logic       cmd_valid_o,
  input  logic       cmd_ready_i,
  output lcdtf_cmd_t cmd_o
);

  localparam int PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CMD_QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CMD_QUEUE_DEPTH);

  lcdtf_cmd_t       cls;
  logic [7:0]       sym_idx;
  logic             sym_ok;
  lcdtf_cmd_t       queue_q [CMD_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  // Classify the incoming item.
  always_comb begin
    sym_idx       = in_data_i.symbol - SYM_FIRST;
    sym_ok        = (in_data_i.symbol >= SYM_FIRST) && (sym_idx < 8'(FONT_GLYPHS));
    cls           = '0;
    cls.kind      = CMD_NOP;
    cls.line      = in_data_i.line;
    cls.glyph     = 12'(sym_idx[6:0]) * 12'(GLYPH_STRIDE);
    cls.fb_addr   = {in_data_i.page, in_data_i.column};
    cls.data      = in_data_i.byte_value;
    cls.font_addr = in_data_i.font_address;
    unique case (in_data_i.op)
      OP_CLEAR: cls.kind = CMD_CLEAR;
      OP_DRAW: begin
        cls.kind    = sym_ok ? CMD_DRAW : CMD_NOP;
        cls.sym_err = !sym_ok;
      end
      OP_OR:    cls.kind = CMD_ORB;
      OP_FLUSH: cls.kind = CMD_FLUSH;
      OP_LOAD: begin
        cls.kind = (in_data_i.font_address < 12'(STORE_BYTES)) ? CMD_LOAD : CMD_NOP;
        cls.data = in_data_i.font_byte;
      end
      default:  cls.kind = CMD_NOP;
    endcase
  end

  // Queue handshakes.
  assign in_ready_o  = (cnt_q != CNT_FULL) && !init_busy_i;
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = queue_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  // Queue pointers and fill count.
  always_comb begin
    wr_d  = push ? ((wr_q == PTR_LAST) ? '0 : wr_q + 1'b1) : wr_q;
    rd_d  = pop ? ((rd_q == PTR_LAST) ? '0 : rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_q] <= cls;
    end
  end

endmodule

/* rtl/lcdtf_back.sv */
// Back end: runs queued commands against the frame buffer and glyph store
// banks and drives the result register. Depends on lcdtf_pkg and lcdtf_ram.

module lcdtf_back
  import lcdtf_pkg::*;
#(
  parameter int GLYPH_COLUMNS = DEF_GLYPH_COLUMNS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cmd_valid_i,
  output logic       cmd_ready_o,
  input  lcdtf_cmd_t cmd_i,
  output logic       init_busy_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lcdtf_out_t out_data_o
);

  localparam int CW = $clog2(GLYPH_COLUMNS + 2);
  localparam logic [CW-1:0]    STEP_WIDTH = CW'(1);
  localparam logic [CW-1:0]    STEP_COL0  = CW'(2);
  localparam logic [CW-1:0]    STEP_LAST  = CW'(GLYPH_COLUMNS + 1);
  localparam logic [FB_AW-1:0] CLR_LAST   = FB_AW'(FB_BANK_DEPTH - 1);
  localparam logic [7:0]       K_LAST     = 8'(PAGE_ITEMS - 1);

  localparam logic [3:0] ST_INIT   = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CLEAR  = 4'd2;
  localparam logic [3:0] ST_DRAW   = 4'd3;
  localparam logic [3:0] ST_ORRD   = 4'd4;
  localparam logic [3:0] ST_ORWR   = 4'd5;
  localparam logic [3:0] ST_FLRD   = 4'd6;
  localparam logic [3:0] ST_FLCAP  = 4'd7;
  localparam logic [3:0] ST_RESULT = 4'd8;

  logic [3:0]         state_q, state_d;
  lcdtf_cmd_t         cmd_q, cmd_d;
  logic [FB_AW-1:0]   clr_q, clr_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [DRAW_AW-1:0] wptr_q, wptr_d;
  logic [PEN_W-1:0]   pen_start_q, pen_start_d;
  logic [7:0]         width_q, width_d;
  logic [PEN_W-1:0]   pen_top_q, pen_top_d, pen_bot_q, pen_bot_d;
  logic [1:0]         fl_page_q, fl_page_d;
  logic [7:0]         fl_k_q, fl_k_d;
  lcdtf_out_t         res_q, res_d;
  lcdtf_out_t         out_q;
  logic               out_valid_q, out_valid_d;
  logic               load_out;

  logic [FB_AW-1:0]   fb_raddr;
  logic               fb_we    [2];
  logic [FB_AW-1:0]   fb_waddr [2];
  logic [7:0]         fb_wdata [2];
  logic [7:0]         fb_rdata [2];
  logic [FONT_AW-1:0] font_raddr [2];
  logic               font_we    [2];
  logic [7:0]         font_rdata [2];

  logic [11:0]        rd_a, rd_b;
  logic [7:0]         lo_byte, hi_byte;
  logic [DRAW_AW-1:0] wl;
  logic [DRAW_AW-1:0] pen_sum;
  logic [PEN_W-1:0]   pen_new;
  logic [PEN_W-1:0]   pen_sel;
  logic [7:0]         fl_kk;
  logic [7:0]         or_rdata;
  logic               pop;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign init_busy_o = (state_q == ST_INIT);
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Glyph reads: step n fetches the byte at glyph + 2n (width or lower byte)
  // and glyph + 2n - 1 (upper byte); glyph parity picks the bank of each.
  always_comb begin
    rd_a          = cmd_q.glyph + 12'({cnt_q, 1'b0});
    rd_b          = rd_a - 12'd1;
    font_raddr[0] = cmd_q.glyph[0] ? rd_b[11:1] : rd_a[11:1];
    font_raddr[1] = cmd_q.glyph[0] ? rd_a[11:1] : rd_b[11:1];
    lo_byte       = cmd_q.glyph[0] ? font_rdata[1] : font_rdata[0];
    hi_byte       = cmd_q.glyph[0] ? font_rdata[0] : font_rdata[1];
  end

  // Glyph store writes happen in the cycle a load command is taken.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      font_we[b] = pop && (cmd_i.kind == CMD_LOAD) && (cmd_i.font_addr[0] == 1'(b));
    end
  end

  // Pen arithmetic for the end of a draw.
  assign pen_sum = DRAW_AW'(pen_start_q) + DRAW_AW'(width_q);
  assign pen_new = (pen_sum > DRAW_AW'(PEN_MAX)) ? PEN_MAX : pen_sum[PEN_W-1:0];
  assign pen_sel = cmd_i.line ? pen_bot_q : pen_top_q;

  // Frame buffer read address: OR read or flush read.
  assign fl_kk    = fl_k_q - 8'(CMD_ITEMS);
  assign fb_raddr = (state_q == ST_ORRD) ? {cmd_q.fb_addr[8], cmd_q.fb_addr[6:0]}
                                         : {fl_page_q[1], fl_kk[6:0]};
  assign or_rdata = cmd_q.fb_addr[7] ? fb_rdata[1] : fb_rdata[0];
  assign wl       = wptr_q + DRAW_AW'(PAGE_COLS);

  // Frame buffer write ports.
  always_comb begin
    for (int b = 0; b < 2; b++) begin
      fb_we[b]    = 1'b0;
      fb_waddr[b] = clr_q;
      fb_wdata[b] = '0;
      unique case (state_q) inside
        ST_INIT, ST_CLEAR: begin
          fb_we[b] = 1'b1;
        end
        ST_DRAW: begin
          if (wptr_q[7] == 1'(b)) begin
            fb_waddr[b] = {wptr_q[8], wptr_q[6:0]};
            fb_wdata[b] = hi_byte;
            fb_we[b]    = (cnt_q >= STEP_COL0) && (wptr_q[10:9] == 2'b00);
          end else begin
            fb_waddr[b] = {wl[8], wl[6:0]};
            fb_wdata[b] = lo_byte;
            fb_we[b]    = (cnt_q >= STEP_COL0) && (wl[10:9] == 2'b00);
          end
        end
        ST_ORWR: begin
          fb_waddr[b] = {cmd_q.fb_addr[8], cmd_q.fb_addr[6:0]};
          fb_wdata[b] = or_rdata | cmd_q.data;
          fb_we[b]    = (cmd_q.fb_addr[7] == 1'(b));
        end
        default: begin
          fb_we[b] = 1'b0;
        end
      endcase
    end
  end

  // Command sequencer.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    wptr_d      = wptr_q;
    pen_start_d = pen_start_q;
    width_d     = width_q;
    pen_top_d   = pen_top_q;
    pen_bot_d   = pen_bot_q;
    fl_page_d   = fl_page_q;
    fl_k_d      = fl_k_q;
    res_d       = res_q;
    load_out    = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          cmd_d = cmd_i;
          res_d = '0;
          unique case (cmd_i.kind)
            CMD_CLEAR: begin
              clr_d     = '0;
              pen_top_d = '0;
              pen_bot_d = '0;
              state_d   = ST_CLEAR;
            end
            CMD_DRAW: begin
              cnt_d       = '0;
              pen_start_d = pen_sel;
              wptr_d      = (cmd_i.line ? LINE1_BASE : '0) + DRAW_AW'(pen_sel);
              state_d     = ST_DRAW;
            end
            CMD_ORB:   state_d = ST_ORRD;
            CMD_FLUSH: state_d = ST_FLRD;
            CMD_LOAD:  state_d = ST_RESULT;
            default: begin
              res_d.symbol_error = cmd_i.sym_err;
              state_d            = ST_RESULT;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_RESULT;
        end
      end
      ST_DRAW: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == STEP_WIDTH) begin
          width_d = lo_byte;
        end
        if (cnt_q >= STEP_COL0) begin
          wptr_d = wptr_q + 1'b1;
        end
        if (cnt_q == STEP_LAST) begin
          if (cmd_q.line) begin
            pen_bot_d = pen_new;
          end else begin
            pen_top_d = pen_new;
          end
          state_d = ST_RESULT;
        end
      end
      ST_ORRD: state_d = ST_ORWR;
      ST_ORWR: state_d = ST_RESULT;
      ST_FLRD: state_d = ST_FLCAP;
      ST_FLCAP: begin
        if (fl_k_q == 8'd0) begin
          res_d.out_byte = DISP_COL_LOW;
        end else if (fl_k_q == 8'd1) begin
          res_d.out_byte = DISP_COL_HIGH;
        end else if (fl_k_q == 8'd2) begin
          res_d.out_byte = DISP_PAGE | {6'd0, fl_page_q};
        end else begin
          res_d.out_byte = fl_page_q[0] ? fb_rdata[1] : fb_rdata[0];
          res_d.is_data  = 1'b1;
        end
        res_d.frame_last = (fl_page_q == 2'd3) && (fl_k_q == K_LAST);
        if (fl_k_q == K_LAST) begin
          fl_k_d    = '0;
          fl_page_d = fl_page_q + 1'b1;
        end else begin
          fl_k_d = fl_k_q + 1'b1;
        end
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      clr_q       <= '0;
      cnt_q       <= '0;
      pen_top_q   <= '0;
      pen_bot_q   <= '0;
      fl_page_q   <= '0;
      fl_k_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      pen_top_q   <= pen_top_d;
      pen_bot_q   <= pen_bot_d;
      fl_page_q   <= fl_page_d;
      fl_k_q      <= fl_k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    wptr_q      <= wptr_d;
    pen_start_q <= pen_start_d;
    width_q     <= width_d;
    res_q       <= res_d;
    if (load_out) begin
      out_q <= res_q;
    end
  end

  // Memory banks.
  for (genvar g = 0; g < 2; g++) begin : g_bank
    lcdtf_ram #(
      .WIDTH (8),
      .DEPTH (FB_BANK_DEPTH)
    ) u_fb_ram (
      .clk_i   (clk_i),
      .we_i    (fb_we[g]),
      .waddr_i (fb_waddr[g]),
      .wdata_i (fb_wdata[g]),
      .raddr_i (fb_raddr),
      .rdata_o (fb_rdata[g])
    );

    lcdtf_ram #(
      .WIDTH (8),
      .DEPTH (FONT_BANK_DEPTH)
    ) u_font_ram (
      .clk_i   (clk_i),
      .we_i    (font_we[g]),
      .waddr_i (cmd_i.font_addr[11:1]),
      .wdata_i (cmd_i.data),
      .raddr_i (font_raddr[g]),
      .rdata_o (font_rdata[g])
    );
  end

`ifndef SYNTHESIS
  // The draw step counter never runs past the last column step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAW) |-> (cnt_q <= STEP_LAST))
    else $error("draw step counter overran");

  // The refresh position within a page stays below the page length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_k_q <= K_LAST)
    else $error("refresh position out of range");

  // A new result only appears from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result loaded outside result state");

  // Commands are never taken during the power-up clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT) |=> !$past(pop))
    else $error("command taken during clearing pass");
`endif

endmodule

/* rtl/lcd_text_framebuffer.sv */
// Top level of the two-line LCD text frame buffer: front end, command queue
// and back end. Depends on lcdtf_pkg, lcdtf_front, lcdtf_back and lcdtf_ram.
//
//   Channel  Signals                               Payload
//   input    in_valid_i / in_ready_o / in_data_i   lcdtf_in_t (op and operands)
//   output   out_valid_o / out_ready_i / out_data_o lcdtf_out_t (one per input)
//
// A draw takes one glyph store read step per column; a clear writes one
// frame buffer row per cycle; OR bytes, flush steps, loads and unused ops
// all pass through one sequencer, one command at a time.
// After reset a clearing pass zeroes the frame buffer; no input
// transfer is taken until it ends.
// A two-entry queue and the output register let input transfers continue
// while a result waits for out_ready_i.

module lcd_text_framebuffer
  import lcdtf_pkg::*;
#(
  parameter int GLYPH_COLUMNS = DEF_GLYPH_COLUMNS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  lcdtf_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output lcdtf_out_t out_data_o
);

  logic       cmd_valid;
  logic       cmd_ready;
  lcdtf_cmd_t cmd;
  logic       init_busy;

  // Accept and classify.
  lcdtf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .init_busy_i (init_busy),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Execute against the memories.
  lcdtf_back #(
    .GLYPH_COLUMNS (GLYPH_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for lcd_text_framebuffer: a directed table, then random
// glyph loads, draws, OR bytes, clears and refresh runs, checked against a predictor.
// Depends on lcdtf_pkg and the RTL of the block.

module testbench;
  import lcdtf_pkg::*;

  localparam int ITEMS       = 1300;
  localparam int LIMIT       = 1500000;
  localparam int FRAME_ITEMS = 4 * PAGE_ITEMS;
  localparam int HOLD_CYCLES = 400;

  // Op codes that the block must ignore.
  localparam logic [2:0] OP_SPARE5 = 3'd5;
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    lcdtf_in_t  item;
    logic       preset;
    lcdtf_out_t want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  lcdtf_in_t  in_data = '0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  lcdtf_out_t out_data_o;

  // Predicted display state.
  logic [7:0] pixels [FRAME_BYTES];
  logic [7:0] glyph_rom [STORE_BYTES];
  bit         loaded [STORE_BYTES];
  logic [9:0] pen_top = '0;
  logic [9:0] pen_bottom = '0;
  int         refresh_pos = 0;

  lcdtf_out_t awaited [$];
  lcdtf_out_t head;
  int         sent = 0;
  int         results_seen = 0;
  int         fails = 0;
  int         cycles = 0;
  bit         hold_done = 1'b0;
  wire        steady = (sent >= 500) && (sent < 700);

  lcd_text_framebuffer u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #5 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic lcdtf_in_t pack_cmd(input logic [2:0] op, input logic line,
                                         input logic [7:0] symbol, input logic [6:0] column,
                                         input logic [1:0] page, input logic [7:0] byte_value,
                                         input logic [11:0] font_address,
                                         input logic [7:0] font_byte);
    lcdtf_in_t it;
    it.op           = op;
    it.line         = line;
    it.symbol       = symbol;
    it.column       = column;
    it.page         = page;
    it.byte_value   = byte_value;
    it.font_address = font_address;
    it.font_byte    = font_byte;
    return it;
  endfunction

  function automatic lcdtf_out_t pack_out(input logic [7:0] out_byte, input logic is_data,
                                          input logic frame_last, input logic symbol_error);
    lcdtf_out_t r;
    r.out_byte     = out_byte;
    r.is_data      = is_data;
    r.frame_last   = frame_last;
    r.symbol_error = symbol_error;
    return r;
  endfunction

  // Every field random, op as given.
  function automatic lcdtf_in_t random_item(input logic [2:0] op);
    lcdtf_in_t   it;
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    it = bits[$bits(lcdtf_in_t)-1:0];
    it.op = op;
    return it;
  endfunction

  // A glyph may be drawn only once all of its store bytes were loaded.
  function automatic bit glyph_ready(input int g);
    for (int j = 0; j < GLYPH_STRIDE; j++) begin
      if (!loaded[g * GLYPH_STRIDE + j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Applies one op to the predicted state and returns the result it yields.
  function automatic lcdtf_out_t render_step(input lcdtf_in_t it);
    lcdtf_out_t r;
    int         addr, gbase, pen, row, sum, page_no, slot, i;
    r = '0;
    case (it.op)
      OP_CLEAR: begin
        foreach (pixels[a]) pixels[a] = 8'h00;
        pen_top = '0;
        pen_bottom = '0;
      end
      OP_DRAW: begin
        if (it.symbol < SYM_FIRST || int'(it.symbol - SYM_FIRST) >= FONT_GLYPHS) begin
          r.symbol_error = 1'b1;
        end else begin
          gbase = int'(it.symbol - SYM_FIRST) * GLYPH_STRIDE;
          pen = it.line ? int'(pen_bottom) : int'(pen_top);
          row = it.line ? int'(LINE1_BASE) : 0;
          // Upper byte to the first page of the pair, lower byte one page down;
          // anything past the end of the buffer is dropped.
          for (i = 0; i < DEF_GLYPH_COLUMNS; i++) begin
            addr = row + i + pen;
            if (addr < FRAME_BYTES) pixels[addr] = glyph_rom[gbase + 2 * i + 1];
            addr = addr + PAGE_COLS;
            if (addr < FRAME_BYTES) pixels[addr] = glyph_rom[gbase + 2 * i + 2];
          end
          sum = pen + int'(glyph_rom[gbase]);
          if (sum > int'(PEN_MAX)) sum = int'(PEN_MAX);
          if (it.line) pen_bottom = sum[9:0];
          else pen_top = sum[9:0];
        end
      end
      OP_OR: begin
        addr = PAGE_COLS * int'(it.page) + int'(it.column);
        pixels[addr] = pixels[addr] | it.byte_value;
      end
      OP_FLUSH: begin
        page_no = refresh_pos / PAGE_ITEMS;
        slot = refresh_pos % PAGE_ITEMS;
        if (slot == 0) r.out_byte = DISP_COL_LOW;
        else if (slot == 1) r.out_byte = DISP_COL_HIGH;
        else if (slot == 2) r.out_byte = DISP_PAGE + 8'(page_no);
        else begin
          r.out_byte = pixels[PAGE_COLS * page_no + slot - CMD_ITEMS];
          r.is_data = 1'b1;
        end
        r.frame_last = (refresh_pos == FRAME_ITEMS - 1);
        refresh_pos = (refresh_pos + 1) % FRAME_ITEMS;
      end
      OP_LOAD: begin
        if (it.font_address < STORE_BYTES) glyph_rom[it.font_address] = it.font_byte;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Offers one item and waits for its transfer; entered and left at a rising edge.
  task automatic offer(input lcdtf_in_t it, input logic preset, input lcdtf_out_t want);
    lcdtf_out_t predicted;
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(negedge clk);
    while (!in_ready_o) @(negedge clk);
    predicted = render_step(it);
    awaited.push_back(preset ? want : predicted);
    if (it.op == OP_LOAD && it.font_address < STORE_BYTES) loaded[it.font_address] = 1'b1;
    sent++;
    @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    row_t       plan [$];
    lcdtf_in_t  it;
    lcdtf_out_t none;
    int         pick, n, g, j;
    int         ready_q [$];

    none = '0;
    foreach (pixels[a]) pixels[a] = 8'h00;
    foreach (glyph_rom[a]) glyph_rom[a] = 8'h00;
    foreach (loaded[a]) loaded[a] = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: refresh commands after reset, buffer extremes, bad symbols,
    // dropped store loads, unused ops and a clear.
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, pack_out(8'h00, 0, 0, 0)});
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, pack_out(8'h10, 0, 0, 0)});
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, pack_out(8'hB0, 0, 0, 0)});
    plan.push_back({pack_cmd(OP_OR, 0, 0, 7'd0, 2'd0, 8'h81, 0, 0), 1'b1, none});
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, pack_out(8'h81, 1, 0, 0)});
    plan.push_back({pack_cmd(OP_OR, 0, 0, 7'd127, 2'd3, 8'hFF, 0, 0), 1'b1, none});
    plan.push_back({pack_cmd(OP_DRAW, 0, 8'd0, 0, 0, 0, 0, 0), 1'b1, pack_out(0, 0, 0, 1)});
    plan.push_back({pack_cmd(OP_DRAW, 1, 8'd31, 0, 0, 0, 0, 0), 1'b1, pack_out(0, 0, 0, 1)});
    plan.push_back({pack_cmd(OP_DRAW, 0, 8'd128, 0, 0, 0, 0, 0), 1'b1, pack_out(0, 0, 0, 1)});
    plan.push_back({pack_cmd(OP_DRAW, 1, 8'd255, 0, 0, 0, 0, 0), 1'b1, pack_out(0, 0, 0, 1)});
    plan.push_back({pack_cmd(OP_LOAD, 0, 0, 0, 0, 0, 12'd2400, 8'hFF), 1'b1, none});
    plan.push_back({pack_cmd(OP_LOAD, 0, 0, 0, 0, 0, 12'd4095, 8'hFF), 1'b1, none});
    plan.push_back({pack_cmd(OP_LOAD, 0, 0, 0, 0, 0, 12'd0, 8'hA5), 1'b1, none});
    plan.push_back({pack_cmd(OP_LOAD, 0, 0, 0, 0, 0, 12'd2399, 8'h5A), 1'b1, none});
    plan.push_back({pack_cmd(OP_SPARE5, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    plan.push_back({pack_cmd(OP_SPARE6, 1, 8'h41, 7'd5, 2'd1, 8'h33, 12'd7, 8'h44), 1'b1, none});
    plan.push_back({pack_cmd(OP_SPARE7, 1, 8'hFF, 7'h7F, 2'd3, 8'hFF, 12'hFFF, 8'hFF), 1'b1,
                    none});
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
    plan.push_back({pack_cmd(OP_OR, 0, 0, 7'd2, 2'd0, 8'h3C, 0, 0), 1'b1, none});
    plan.push_back({pack_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1'b1, none});
    plan.push_back({pack_cmd(OP_FLUSH, 0, 0, 0, 0, 0, 0, 0), 1'b1, pack_out(8'h00, 1, 0, 0)});
    foreach (plan[r]) offer(plan[r].item, plan[r].preset, plan[r].want);

    // Random part: a whole glyph load first, then whole glyph loads, draws,
    // refresh runs, OR bursts, clears and some noise, picked at random.
    pick = 0;
    while (sent < ITEMS) begin
      if (pick >= 2) pick = $urandom_range(99);
      else pick = pick + 40;
      if (pick < 28) begin
        n = $urandom_range(1, 70);
        repeat (n) offer(random_item(OP_FLUSH), 1'b0, none);
      end else if (pick < 42) begin
        g = $urandom_range(0, FONT_GLYPHS - 1);
        for (j = 0; j < GLYPH_STRIDE; j++) begin
          it = random_item(OP_LOAD);
          it.font_address = 12'(g * GLYPH_STRIDE + j);
          // Width byte: mostly narrow, sometimes wide enough to saturate a pen.
          if (j == 0) begin
            it.font_byte = ($urandom_range(99) < 15) ? 8'($urandom_range(200, 255))
                                                     : 8'($urandom_range(0, 12));
          end
          offer(it, 1'b0, none);
        end
      end else if (pick < 64) begin
        ready_q.delete();
        for (g = 0; g < FONT_GLYPHS; g++) if (glyph_ready(g)) ready_q.push_back(g);
        n = $urandom_range(1, 8);
        repeat (n) begin
          it = random_item(OP_DRAW);
          if (ready_q.size() == 0 || $urandom_range(99) < 15) begin
            it.symbol = $urandom_range(1) ? 8'($urandom_range(0, 31))
                                          : 8'($urandom_range(128, 255));
          end else begin
            it.symbol = SYM_FIRST + 8'(ready_q[$urandom_range(ready_q.size() - 1)]);
          end
          offer(it, 1'b0, none);
        end
      end else if (pick < 78) begin
        n = $urandom_range(1, 6);
        repeat (n) offer(random_item(OP_OR), 1'b0, none);
      end else if (pick < 84) begin
        offer(random_item(OP_CLEAR), 1'b0, none);
      end else begin
        it = random_item(3'($urandom_range(0, 7)));
        if (it.op == OP_DRAW && it.symbol >= SYM_FIRST && it.symbol < SYM_FIRST + FONT_GLYPHS
            && !glyph_ready(int'(it.symbol - SYM_FIRST))) begin
          it.symbol[7] = 1'b1;
        end
        offer(it, 1'b0, none);
      end
    end

    // Drain and settle.
    in_valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off so the block backs up.
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!hold_done && results_seen >= 250) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 6);
      end
    end
  end

  // A transfer happens at the next rising edge when both are high here.
  always @(negedge clk) begin
    if (out_valid_o && out_ready) begin
      results_seen++;
      if (awaited.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result %h with nothing awaited", out_data_o);
      end else begin
        head = awaited.pop_front();
        if (out_data_o.out_byte !== head.out_byte || out_data_o.is_data !== head.is_data
            || out_data_o.frame_last !== head.frame_last
            || out_data_o.symbol_error !== head.symbol_error) begin
          fails++;
          if (fails <= 10) begin
            $display("result %0d: expected byte %h data %b last %b error %b",
                     results_seen, head.out_byte, head.is_data, head.frame_last,
                     head.symbol_error);
            $display("  got byte %h data %b last %b error %b", out_data_o.out_byte,
                     out_data_o.is_data, out_data_o.frame_last, out_data_o.symbol_error);
          end
        end
      end
    end
  end

endmodule
